// ----- rtl/lfid_pkg.sv -----
// Shared constants, types and codes for the lowest-free ID allocator.
package lfid_pkg;

	localparam int SLOTS       = 64;
	localparam int CELL_W      = 8;
	localparam int NCELLS      = SLOTS / CELL_W;
	localparam int IDX_W       = $clog2(SLOTS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int OFF_W       = $clog2(CELL_W);
	localparam int CELL_IDX_W  = IDX_W - OFF_W;

	localparam int ID_W        = 6;
	localparam int MARK_W      = 7;
	localparam int IN_TDATA_W  = ((ID_W + 7) / 8) * 8;
	localparam int OUT_W       = ID_W + 2 * MARK_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN_FWD,
		S_SCAN_BWD,
		S_RESP
	} state_t;

	// Per-cell write and scan-start controls from the sequencer
	typedef struct packed {
		logic             set;
		logic             clr;
		logic [OFF_W-1:0] wr_off;
		logic             fwd_inj;
		logic             bwd_inj;
		logic [OFF_W-1:0] start_off;
	} cell_ctrl_t;

	// Per-cell scan status back to the sequencer
	typedef struct packed {
		logic             fwd_tok;
		logic             bwd_tok;
		logic             fwd_hit;
		logic             bwd_hit;
		logic [OFF_W-1:0] fwd_pos;
		logic [OFF_W-1:0] bwd_pos;
	} cell_res_t;

endpackage

// ----- rtl/lfid_cell.sv -----
// One cell of the slot chain: a group of occupancy bits and the two scan tokens.
module lfid_cell import lfid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       fwd_in,
	input  logic       bwd_in,
	output logic       fwd_out,
	output logic       bwd_out,
	output cell_res_t  res
);

	logic [CELL_W-1:0] occ_q;
	logic              fwd_tok_q;
	logic              bwd_tok_q;
	logic [OFF_W-1:0]  fwd_off_q;
	logic [OFF_W-1:0]  bwd_off_q;
	logic [CELL_W-1:0] fwd_cand;
	logic [CELL_W-1:0] bwd_cand;
	logic [OFF_W-1:0]  fwd_pos;
	logic [OFF_W-1:0]  bwd_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			fwd_tok_q <= 1'b0;
			bwd_tok_q <= 1'b0;
			fwd_off_q <= '0;
			bwd_off_q <= '0;
		end else begin
			if (ctrl.set) begin
				occ_q[ctrl.wr_off] <= 1'b1;
			end
			if (ctrl.clr) begin
				occ_q[ctrl.wr_off] <= 1'b0;
			end
			fwd_tok_q <= ctrl.fwd_inj | fwd_in;
			fwd_off_q <= ctrl.fwd_inj ? ctrl.start_off : '0;
			bwd_tok_q <= ctrl.bwd_inj | bwd_in;
			bwd_off_q <= ctrl.bwd_inj ? ctrl.start_off : OFF_W'(CELL_W - 1);
		end
	end

	// forward: free slots at or above the offset; backward: used slots at or below it
	always_comb begin
		fwd_cand = ~occ_q & ({CELL_W{1'b1}} << fwd_off_q);
		bwd_cand = occ_q & ({CELL_W{1'b1}} >> (OFF_W'(CELL_W - 1) - bwd_off_q));
		fwd_pos  = '0;
		bwd_pos  = '0;
		for (int i = CELL_W - 1; i >= 0; i--) begin
			if (fwd_cand[i]) begin
				fwd_pos = OFF_W'(i);
			end
		end
		for (int i = 0; i < CELL_W; i++) begin
			if (bwd_cand[i]) begin
				bwd_pos = OFF_W'(i);
			end
		end
	end

	// a token that finds nothing moves on to the neighbour
	assign fwd_out     = fwd_tok_q & ~(|fwd_cand);
	assign bwd_out     = bwd_tok_q & ~(|bwd_cand);
	assign res.fwd_tok = fwd_tok_q;
	assign res.bwd_tok = bwd_tok_q;
	assign res.fwd_hit = fwd_tok_q & (|fwd_cand);
	assign res.bwd_hit = bwd_tok_q & (|bwd_cand);
	assign res.fwd_pos = fwd_pos;
	assign res.bwd_pos = bwd_pos;

endmodule

// ----- rtl/lowest_free_id_allocator.sv -----
// Lowest-free ID allocator: request sequencer over a chain of slot cells.
// Usage:
//   Requests enter on s_tvalid/s_tready. s_tuser holds the opcode
//   (allocate or free), s_tdata the ID to free. Each request gives one
//   response on m_tvalid/m_tready: m_tuser is the status flag, m_tdata the
//   granted ID, the first-free hint and the end mark after the request.
//   The slots live in a row of cells of CELL_W slots each. The hint and
//   end-mark searches pass a token along the row, one cell per cycle.
//   No search is needed when the table is full, for a free of an
//   out-of-range ID, for a free with end mark zero, or for an allocate
//   of the last slot; otherwise the response waits until the token has
//   walked the cells to the slot it finds or to the end of the row.
//   One request is in work at a time; the next is taken once the previous
//   response sits in the output register.
//   If the receiver stalls, the finished response waits in the output
//   register and a following request is still taken and worked on; its
//   response is held back until the output register frees.
//   Reset clears all occupancy bits, the hint and the end mark at once.
module lowest_free_id_allocator import lfid_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [5:0] release_id, [7:6] zero
	input  logic [0:0]             s_tuser,  // [0] opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [5:0] granted_id, [12:6] hint_after,
	                                         // [19:13] end_after, [23:20] zero
	output logic [0:0]             m_tuser   // [0] status
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] ff_q, ff_d;
	logic [CNT_W-1:0] end_q, end_d;
	logic             status_q, status_d;
	logic [ID_W-1:0]  granted_q, granted_d;

	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_data_q;
	logic             m_status_q;

	logic                  do_set, do_clr, inj_fwd, inj_bwd, load_out;
	logic [CELL_IDX_W-1:0] wr_cell, inj_cell;
	logic [OFF_W-1:0]      wr_off, inj_off;
	logic [CNT_W-1:0]      next_id, end_m1, fwd_ext, rel_ext;
	logic [ID_W-1:0]       rel_id;
	op_t                   op;

	cell_ctrl_t ctrl [NCELLS];
	cell_res_t  res  [NCELLS];
	logic [NCELLS:0] fwd_link;
	logic [NCELLS:0] bwd_link;

	logic             fwd_hit, bwd_hit;
	logic [IDX_W-1:0] fwd_idx, bwd_idx;
	logic [NCELLS-1:0] fwd_toks, bwd_toks;

	assign op      = op_t'(s_tuser[0]);
	assign rel_id  = s_tdata[ID_W-1:0];
	assign rel_ext = CNT_W'(rel_id);
	assign next_id = ff_q + CNT_W'(1);
	assign end_m1  = end_q - CNT_W'(1);
	assign fwd_ext = CNT_W'(fwd_idx);

	assign fwd_link[0]      = 1'b0;
	assign bwd_link[NCELLS] = 1'b0;

	for (genvar k = 0; k < NCELLS; k++) begin : g_cell
		lfid_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl[k]),
			.fwd_in  (fwd_link[k]),
			.bwd_in  (bwd_link[k+1]),
			.fwd_out (fwd_link[k+1]),
			.bwd_out (bwd_link[k]),
			.res     (res[k])
		);
	end

	// fan the controls out to the addressed cell
	always_comb begin
		for (int k = 0; k < NCELLS; k++) begin
			ctrl[k].set       = do_set && (wr_cell == CELL_IDX_W'(k));
			ctrl[k].clr       = do_clr && (wr_cell == CELL_IDX_W'(k));
			ctrl[k].wr_off    = wr_off;
			ctrl[k].fwd_inj   = inj_fwd && (inj_cell == CELL_IDX_W'(k));
			ctrl[k].bwd_inj   = inj_bwd && (inj_cell == CELL_IDX_W'(k));
			ctrl[k].start_off = inj_off;
		end
	end

	// only the cell holding the token can report a hit
	always_comb begin
		fwd_hit = 1'b0;
		bwd_hit = 1'b0;
		fwd_idx = '0;
		bwd_idx = '0;
		for (int k = 0; k < NCELLS; k++) begin
			fwd_toks[k] = res[k].fwd_tok;
			bwd_toks[k] = res[k].bwd_tok;
			if (res[k].fwd_hit) begin
				fwd_hit = 1'b1;
				fwd_idx = {CELL_IDX_W'(k), res[k].fwd_pos};
			end
			if (res[k].bwd_hit) begin
				bwd_hit = 1'b1;
				bwd_idx = {CELL_IDX_W'(k), res[k].bwd_pos};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ff_d      = ff_q;
		end_d     = end_q;
		status_d  = status_q;
		granted_d = granted_q;
		do_set    = 1'b0;
		do_clr    = 1'b0;
		wr_cell   = '0;
		wr_off    = '0;
		inj_fwd   = 1'b0;
		inj_bwd   = 1'b0;
		inj_cell  = '0;
		inj_off   = '0;
		load_out  = 1'b0;
		s_tready  = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (op == OP_ALLOC) begin
						if (ff_q >= CNT_W'(SLOTS)) begin
							status_d  = ST_FULL;
							granted_d = '0;
							state_d   = S_RESP;
						end else begin
							status_d  = ST_DONE;
							granted_d = ID_W'(ff_q);
							do_set    = 1'b1;
							wr_cell   = ff_q[IDX_W-1:OFF_W];
							wr_off    = ff_q[OFF_W-1:0];
							if (next_id == CNT_W'(SLOTS)) begin
								ff_d    = CNT_W'(SLOTS);
								end_d   = CNT_W'(SLOTS);
								state_d = S_RESP;
							end else begin
								inj_fwd  = 1'b1;
								inj_cell = next_id[IDX_W-1:OFF_W];
								inj_off  = next_id[OFF_W-1:0];
								state_d  = S_SCAN_FWD;
							end
						end
					end else begin
						status_d  = ST_DONE;
						granted_d = '0;
						if (rel_ext >= CNT_W'(SLOTS)) begin
							state_d = S_RESP;
						end else begin
							do_clr  = 1'b1;
							wr_cell = rel_ext[IDX_W-1:OFF_W];
							wr_off  = rel_ext[OFF_W-1:0];
							if (ff_q > rel_ext) begin
								ff_d = rel_ext;
							end
							if (end_q == '0) begin
								state_d = S_RESP;
							end else begin
								// cleared bit is visible by the time the token looks
								inj_bwd  = 1'b1;
								inj_cell = end_m1[IDX_W-1:OFF_W];
								inj_off  = end_m1[OFF_W-1:0];
								state_d  = S_SCAN_BWD;
							end
						end
					end
				end
			end
			S_SCAN_FWD: begin
				if (fwd_hit) begin
					ff_d    = fwd_ext;
					end_d   = (end_q < fwd_ext) ? fwd_ext : end_q;
					state_d = S_RESP;
				end else if (fwd_link[NCELLS]) begin
					ff_d    = CNT_W'(SLOTS);
					end_d   = CNT_W'(SLOTS);
					state_d = S_RESP;
				end
			end
			S_SCAN_BWD: begin
				if (bwd_hit) begin
					end_d   = CNT_W'(bwd_idx) + CNT_W'(1);
					state_d = S_RESP;
				end else if (bwd_link[0]) begin
					end_d   = '0;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q  <= '0;
			end_q <= '0;
		end else begin
			ff_q  <= ff_d;
			end_q <= end_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		granted_q <= granted_d;
		if (load_out) begin
			m_status_q <= status_q;
			m_data_q   <= {MARK_W'(end_q), MARK_W'(ff_q), granted_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = m_status_q;
	assign m_tdata    = {{(OUT_TDATA_W - OUT_W){1'b0}}, m_data_q};

	// at most one scan token anywhere in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({fwd_toks, bwd_toks}))
		else $error("more than one scan token in the cell chain");

	// a search state always has a token in flight
	a_scan_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_FWD || state_q == S_SCAN_BWD) |->
		((|fwd_toks) || (|bwd_toks)))
		else $error("scan state with no token in the chain");

	// hint and end mark never pass the table size
	a_marks_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ff_q <= CNT_W'(SLOTS)) && (end_q <= CNT_W'(SLOTS)))
		else $error("hint or end mark out of range");

	// a full-table response grants nothing and reports a full hint
	a_full_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == ST_FULL) |->
		(m_tdata[ID_W-1:0] == '0 && m_tdata[ID_W+MARK_W-1:ID_W] == MARK_W'(SLOTS)))
		else $error("full response with a granted ID or a free hint");

endmodule
